### rtl/core/i2cras_pkg.sv
`default_nettype none
package i2cras_pkg;

  // sizes
  localparam int BUFFER_BYTES_DEF = 16;
  localparam int MAX_LEN          = 16;

  // address byte forms
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  // request opcodes
  localparam logic [1:0] OP_LOAD        = 2'd0;
  localparam logic [1:0] OP_START_READ  = 2'd1;
  localparam logic [1:0] OP_START_WRITE = 2'd2;
  localparam logic [1:0] OP_BUS_EVENT   = 2'd3;

  // sequencer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_REGADDR = 3'd1;
  localparam logic [2:0] PH_RSTART  = 3'd2;
  localparam logic [2:0] PH_DUMMY   = 3'd3;
  localparam logic [2:0] PH_READ    = 3'd4;
  localparam logic [2:0] PH_WRITE   = 3'd5;

  // start kinds
  localparam logic [1:0] START_NONE    = 2'd0;
  localparam logic [1:0] START_TAKE    = 2'd1;
  localparam logic [1:0] START_REPEAT  = 2'd2;

  // end codes
  localparam logic [2:0] END_RUN   = 3'd0;
  localparam logic [2:0] END_NOACK = 3'd1;
  localparam logic [2:0] END_READ  = 3'd2;
  localparam logic [2:0] END_WRITE = 3'd3;
  localparam logic [2:0] END_BUSY  = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] buffer_index;
    logic [7:0] buffer_byte;
    logic [7:0] register_address;
    logic [4:0] transfer_length;
    logic       bus_busy;
    logic       ack_received;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [1:0] start_kind;
    logic       receive_mode;
    logic       nack_next;
    logic       stop;
    logic       read_valid;
    logic [3:0] read_index;
    logic [7:0] read_byte;
    logic [2:0] end_code;
  } out_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       is_read;
    logic [4:0] byte_count;
    logic [4:0] length;
    logic [7:0] reg_addr;
  } seq_state_t;

endpackage
`default_nettype wire

### rtl/core/i2cras_wbuf.sv
`default_nettype none
module i2cras_wbuf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] buf_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // byte store, contents undefined until loaded
  always_ff @(posedge clk) begin
    if (we) begin
      buf_r[waddr] <= wdata;
    end
  end

  // registered read, write-first when both ports hit the same slot
  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= buf_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/i2cras_step.sv
`default_nettype none
module i2cras_step #(
  parameter int DEPTH = 16
) (
  input  wire i2cras_pkg::in_item_t   item,
  input  wire i2cras_pkg::seq_state_t state,
  input  wire logic [6:0]             dev_addr,
  input  wire logic [7:0]             buf_rdata,
  output i2cras_pkg::out_item_t       result,
  output i2cras_pkg::seq_state_t      state_nxt
);
  import i2cras_pkg::*;

  localparam logic [4:0] WR_CAP  = 5'(DEPTH);
  localparam logic [4:0] RD_CAP  = 5'(MAX_LEN);

  logic [7:0] wr_addr_byte;
  logic [7:0] rd_addr_byte;
  logic [4:0] len_clip;
  logic [5:0] cnt_p1;
  logic [5:0] cnt_p2;
  logic [5:0] len_ext;

  assign wr_addr_byte = {dev_addr, 1'b0} & ADDR_WR_MASK;
  assign rd_addr_byte = {dev_addr, 1'b0} | ADDR_RD_BIT;
  assign cnt_p1       = {1'b0, state.byte_count} + 6'd1;
  assign cnt_p2       = {1'b0, state.byte_count} + 6'd2;
  assign len_ext      = {1'b0, state.length};

  // length clipping for a new transfer
  always_comb begin
    len_clip = (item.transfer_length > RD_CAP) ? RD_CAP : item.transfer_length;
    if (item.opcode == OP_START_READ) begin
      if (len_clip == 5'd0) begin
        len_clip = 5'd1;
      end
    end else if (len_clip > WR_CAP) begin
      len_clip = WR_CAP;
    end
  end

  // one request: result fields and next sequencer state
  always_comb begin
    result    = '0;
    state_nxt = state;
    if (item.opcode inside {OP_START_READ, OP_START_WRITE}) begin
      if (item.bus_busy || state.phase != PH_IDLE) begin
        result.end_code = END_BUSY;
      end else begin
        state_nxt.is_read    = (item.opcode == OP_START_READ);
        state_nxt.length     = len_clip;
        state_nxt.reg_addr   = item.register_address;
        state_nxt.byte_count = 5'd0;
        state_nxt.phase      = PH_REGADDR;
        result.send_valid    = 1'b1;
        result.send_byte     = wr_addr_byte;
        result.start_kind    = START_TAKE;
      end
    end else if (item.opcode == OP_BUS_EVENT) begin
      // missing ack ends the regaddr, rstart, dummy and write phases with a fault
      if (!item.ack_received && state.phase inside {PH_REGADDR, PH_RSTART, PH_DUMMY,
                                                     PH_WRITE}) begin
        result.stop     = 1'b1;
        result.end_code = END_NOACK;
        state_nxt.phase = PH_IDLE;
      end else begin
        case (state.phase)
          PH_IDLE: begin
            state_nxt.phase = PH_IDLE;
          end
          PH_REGADDR: begin
            result.send_valid = 1'b1;
            result.send_byte  = state.reg_addr;
            state_nxt.phase   = state.is_read ? PH_RSTART : PH_WRITE;
          end
          PH_RSTART: begin
            result.send_valid = 1'b1;
            result.send_byte  = rd_addr_byte;
            result.start_kind = START_REPEAT;
            state_nxt.phase   = PH_DUMMY;
          end
          PH_DUMMY: begin
            result.receive_mode = 1'b1;
            result.nack_next    = (state.length <= 5'd1);
            state_nxt.phase     = PH_READ;
          end
          PH_READ: begin
            result.read_valid = 1'b1;
            result.read_index = state.byte_count[3:0];
            result.read_byte  = item.received_byte;
            if (cnt_p1 >= len_ext) begin
              result.stop     = 1'b1;
              result.end_code = END_READ;
              state_nxt.phase = PH_IDLE;
            end else begin
              result.nack_next     = (cnt_p2 == len_ext);
              state_nxt.byte_count = cnt_p1[4:0];
            end
          end
          PH_WRITE: begin
            if (state.byte_count >= state.length) begin
              result.stop     = 1'b1;
              result.end_code = END_WRITE;
              state_nxt.phase = PH_IDLE;
            end else begin
              result.send_valid    = 1'b1;
              result.send_byte     = buf_rdata;
              state_nxt.byte_count = cnt_p1[4:0];
            end
          end
          default: begin
            state_nxt.phase = PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/i2c_register_access_sequencer.sv
`default_nettype none
// I2C master register access sequencer.
// Requests arrive on the in_ channel (valid/stall) as one packed item: a write
// buffer load, a start read, a start write or a bus event. Each request gives
// exactly one result on the out_ channel, telling the master what to do next
// (send a byte, START or repeated START, receive mode, NACK, STOP) and any
// received byte or end code.
// The device address is set through cfg_we/cfg_wdata; the user must write it
// only while no transfer runs, as the block itself does not enforce this.
// A taken request sits in the input register, is decoded against the
// sequencer state by a single pass of logic and lands in the result register.
// One request is taken every cycle while in_stall is low.
// When the receiver stalls, the result register holds; the input register
// keeps taking a request until it too is full, and then in_stall rises.
// Reset clears the sequencer to idle and the device address to zero; the
// write buffer is not cleared and must be loaded before a write uses it.
module i2c_register_access_sequencer #(
  parameter int BUFFER_BYTES = i2cras_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire i2cras_pkg::in_item_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output i2cras_pkg::out_item_t     out_data,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_wdata
);
  import i2cras_pkg::*;

  localparam int DEPTH = (BUFFER_BYTES < MAX_LEN) ? BUFFER_BYTES : MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0] SLOTS = 9'(BUFFER_BYTES);

  logic          s1_valid_r;
  in_item_t      s1_item_r;
  logic          out_valid_r;
  out_item_t     out_data_r;
  seq_state_t    state_r;
  seq_state_t    state_nxt;
  out_item_t     result;
  logic [6:0]    dev_addr_r;
  logic          adv;
  logic          proc;
  logic          buf_we;
  logic [AW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;

  // the result register can take a new result
  assign adv      = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // device address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd0;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  // write buffer
  assign buf_we = proc && (s1_item_r.opcode == OP_LOAD) &&
                  ({5'd0, s1_item_r.buffer_index} < SLOTS);

  // fetch the slot the sequencer will point at after this edge
  assign buf_raddr = proc ? state_nxt.byte_count[AW-1:0] : state_r.byte_count[AW-1:0];

  i2cras_wbuf #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wbuf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (s1_item_r.buffer_index[AW-1:0]),
    .wdata (s1_item_r.buffer_byte),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // request decode
  i2cras_step #(
    .DEPTH (DEPTH)
  ) u_step (
    .item      (s1_item_r),
    .state     (state_r),
    .dev_addr  (dev_addr_r),
    .buf_rdata (buf_rdata),
    .result    (result),
    .state_nxt (state_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a stop always returns the sequencer to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    proc && result.stop |=> state_r.phase == PH_IDLE)
    else $error("stop issued but sequencer not idle");

  // byte position never passes the latched length
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_count <= state_r.length)
    else $error("byte count beyond transfer length");

  // a received byte is only returned from the read phase
  assert property (@(posedge clk) disable iff (!rst_n)
    proc && result.read_valid |-> state_r.phase == PH_READ)
    else $error("read byte outside read phase");

endmodule
`default_nettype wire

### tb/testbench.sv
module testbench;
  import i2cras_pkg::*;

  localparam int HOLD_CYCLES = 60;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // dut ports
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  i2c_register_access_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // sequencer copy used for prediction
  logic [2:0] seq_phase = PH_IDLE;
  logic       seq_is_read = 1'b0;
  logic [4:0] seq_count = '0;
  logic [4:0] seq_length = '0;
  logic [7:0] seq_register = '0;
  logic [6:0] device_addr = '0;
  logic [7:0] wbuf [16];
  bit         wbuf_loaded [16];

  out_item_t due_actions [$];
  int        errors = 0;
  int        requests_sent = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_asked = 0;
  int        hold_taken = 0;
  int        hold_left = 0;

  // master action expected for one request, advancing the sequencer copy
  function automatic out_item_t next_action(in_item_t r);
    out_item_t  act;
    logic [4:0] len;
    act = '0;
    if (r.opcode == OP_LOAD) begin
      wbuf[r.buffer_index] = r.buffer_byte;
      wbuf_loaded[r.buffer_index] = 1'b1;
    end else if (r.opcode == OP_START_READ || r.opcode == OP_START_WRITE) begin
      if (r.bus_busy || seq_phase != PH_IDLE) begin
        act.end_code = END_BUSY;
      end else begin
        len = (r.transfer_length > MAX_LEN) ? 5'(MAX_LEN) : r.transfer_length;
        seq_is_read = (r.opcode == OP_START_READ);
        if (seq_is_read && len == 0)
          len = 5'd1;
        seq_length = len;
        seq_register = r.register_address;
        seq_count = '0;
        seq_phase = PH_REGADDR;
        act.send_valid = 1'b1;
        act.send_byte = {device_addr, 1'b0} & ADDR_WR_MASK;
        act.start_kind = START_TAKE;
      end
    end else begin
      case (seq_phase)
        PH_REGADDR, PH_RSTART, PH_DUMMY, PH_WRITE: begin
          if (!r.ack_received) begin
            // missing ack: stop with a fault
            act.stop = 1'b1;
            act.end_code = END_NOACK;
            seq_phase = PH_IDLE;
          end else if (seq_phase == PH_REGADDR) begin
            act.send_valid = 1'b1;
            act.send_byte = seq_register;
            seq_phase = seq_is_read ? PH_RSTART : PH_WRITE;
          end else if (seq_phase == PH_RSTART) begin
            act.send_valid = 1'b1;
            act.send_byte = {device_addr, 1'b0} | ADDR_RD_BIT;
            act.start_kind = START_REPEAT;
            seq_phase = PH_DUMMY;
          end else if (seq_phase == PH_DUMMY) begin
            act.receive_mode = 1'b1;
            act.nack_next = (seq_length <= 1);
            seq_phase = PH_READ;
          end else if (seq_count >= seq_length) begin
            act.stop = 1'b1;
            act.end_code = END_WRITE;
            seq_phase = PH_IDLE;
          end else begin
            act.send_valid = 1'b1;
            act.send_byte = wbuf[seq_count[3:0]];
            seq_count = seq_count + 5'd1;
          end
        end
        PH_READ: begin
          act.read_valid = 1'b1;
          act.read_index = seq_count[3:0];
          act.read_byte = r.received_byte;
          if (int'(seq_count) + 1 >= int'(seq_length)) begin
            act.stop = 1'b1;
            act.end_code = END_READ;
            seq_phase = PH_IDLE;
          end else begin
            if (int'(seq_count) + 2 == int'(seq_length))
              act.nack_next = 1'b1;
            seq_count = seq_count + 5'd1;
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    return act;
  endfunction

  // true when every slot a write of this length sends has been loaded
  function automatic bit slots_ready(logic [4:0] len);
    int n;
    n = (len > 16) ? 16 : int'(len);
    for (int i = 0; i < n; i++)
      if (!wbuf_loaded[i])
        return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_item_t make_request(logic [1:0] op, logic [3:0] idx, logic [7:0] data,
                                            logic [7:0] regaddr, logic [4:0] len, logic busy,
                                            logic ack, logic [7:0] rx);
    in_item_t r;
    r.opcode = op;
    r.buffer_index = idx;
    r.buffer_byte = data;
    r.register_address = regaddr;
    r.transfer_length = len;
    r.bus_busy = busy;
    r.ack_received = ack;
    r.received_byte = rx;
    return r;
  endfunction

  function automatic in_item_t random_request();
    return make_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  // offer one request, wait for it to be taken, then predict its action
  task automatic send_request(in_item_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    due_actions.push_back(next_action(r));
    requests_sent++;
  endtask

  // stop offering and wait until every expected action has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_actions.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_device_address(logic [6:0] addr);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    device_addr = addr;
  endtask

  // bus events until the running transfer ends, with the odd refused start or load
  task automatic run_bus_events();
    in_item_t r;
    int pick;
    while (seq_phase != PH_IDLE) begin
      r = random_request();
      pick = $urandom_range(0, 29);
      if (pick == 0)
        r.opcode = $urandom_range(0, 1) ? OP_START_READ : OP_START_WRITE;
      else if (pick == 1)
        r.opcode = OP_LOAD;
      else begin
        r.opcode = OP_BUS_EVENT;
        r.ack_received = ($urandom_range(0, 39) != 0);
      end
      send_request(r);
    end
  endtask

  function automatic logic [4:0] random_length();
    return 5'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16));
  endfunction

  task automatic run_write_transfer();
    in_item_t r;
    logic [4:0] len;
    len = random_length();
    for (int i = 0; i < ((len > 16) ? 16 : int'(len)); i++) begin
      r = random_request();
      r.opcode = OP_LOAD;
      r.buffer_index = 4'(i);
      send_request(r);
    end
    r = random_request();
    r.opcode = OP_START_WRITE;
    r.transfer_length = len;
    r.bus_busy = ($urandom_range(0, 19) == 0);
    send_request(r);
    run_bus_events();
  endtask

  task automatic run_read_transfer();
    in_item_t r;
    r = random_request();
    r.opcode = OP_START_READ;
    r.transfer_length = random_length();
    r.bus_busy = ($urandom_range(0, 19) == 0);
    send_request(r);
    run_bus_events();
  endtask

  // write with extreme data and register values
  task automatic test_write_extremes();
    write_device_address(7'h7F);
    send_request(make_request(OP_LOAD, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_LOAD, 4'd1, 8'hFF, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_LOAD, 4'd15, 8'hA5, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_START_WRITE, 4'd0, 8'h00, 8'hFF, 5'd2, 1'b0, 1'b0, 8'h00));
    repeat (4)
      send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1, 8'h00));
  endtask

  // read of length zero, counted as one byte with nack up front
  task automatic test_read_single_byte();
    send_request(make_request(OP_START_READ, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00));
    repeat (3)
      send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1, 8'h00));
    send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'hFF));
  endtask

  // quiet event, busy bus, start while running, missing acks, empty write
  task automatic test_refusals_and_faults();
    send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1, 8'h5A));
    send_request(make_request(OP_START_WRITE, 4'd0, 8'h00, 8'h12, 5'd1, 1'b1, 1'b0, 8'h00));
    send_request(make_request(OP_START_READ, 4'd0, 8'h00, 8'h34, 5'd2, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1, 8'h00));
    send_request(make_request(OP_START_WRITE, 4'd0, 8'h00, 8'h56, 5'd1, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_START_WRITE, 4'd0, 8'h00, 8'h78, 5'd0, 1'b0, 1'b0, 8'h00));
    repeat (2)
      send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1, 8'h00));
    send_request(make_request(OP_START_WRITE, 4'd0, 8'h00, 8'h9A, 5'd1, 1'b0, 1'b0, 8'h00));
    send_request(make_request(OP_BUS_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00));
  endtask

  // receiver holds off while a read streams in, then the sender waits for it all
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_asked++;
    send_request(make_request(OP_START_READ, 4'd0, 8'h00, 8'hC3, 5'd8, 1'b0, 1'b0, 8'h00));
    run_bus_events();
    wait_drained();
  endtask

  // random transfers and noise under one idling mix
  task automatic test_random_traffic(int send_idle, int recv_stall, int count);
    in_item_t r;
    int goal;
    int pick;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        run_write_transfer();
      else if (pick < 8)
        run_read_transfer();
      else begin
        r = random_request();
        if (r.opcode == OP_START_WRITE && !r.bus_busy && seq_phase == PH_IDLE &&
            !slots_ready(r.transfer_length))
          r.opcode = OP_LOAD;
        send_request(r);
        run_bus_events();
      end
    end
    wait_drained();
  endtask

  // receiver side: random stall, or a long counted hold when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // compare each taken action with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_actions.size() == 0) begin
        errors++;
        $display("%0t: unexpected action expected none got %h", $time, out_data);
      end else begin
        want = due_actions.pop_front();
        check_field("send_valid", 8'(want.send_valid), 8'(out_data.send_valid));
        check_field("send_byte", want.send_byte, out_data.send_byte);
        check_field("start_kind", 8'(want.start_kind), 8'(out_data.start_kind));
        check_field("receive_mode", 8'(want.receive_mode), 8'(out_data.receive_mode));
        check_field("nack_next", 8'(want.nack_next), 8'(out_data.nack_next));
        check_field("stop", 8'(want.stop), 8'(out_data.stop));
        check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
        check_field("read_index", 8'(want.read_index), 8'(out_data.read_index));
        check_field("read_byte", want.read_byte, out_data.read_byte);
        check_field("end_code", 8'(want.end_code), 8'(out_data.end_code));
      end
    end
  end

  // test sequence
  initial begin
    for (int i = 0; i < 16; i++) begin
      wbuf[i] = '0;
      wbuf_loaded[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_write_extremes();
    test_read_single_byte();
    test_refusals_and_faults();
    wait_drained();
    test_backpressure();
    write_device_address(7'h00);
    test_random_traffic(0, 0, 250);
    write_device_address(7'h55);
    test_random_traffic(46, 0, 250);
    write_device_address(7'($urandom_range(0, 127)));
    test_random_traffic(0, 46, 250);
    write_device_address(7'h7F);
    test_random_traffic(10, 10, 250);
    if (errors == 0 && due_actions.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
